// File: hw/rtl/bprr_pkg.sv
// Shared types and constants for the button pattern record and replay block.
package bprr_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_GAP    = 1'b1;

    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd676;
    localparam logic [CFG_W-1:0] FINAL_GAP_RST    = 16'd100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Button level change seen on one tick.
    typedef enum logic [1:0] {
        EV_HOLD,
        EV_RISE,
        EV_FALL
    } event_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_PLAY
    } back_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] idle_timeout;
        logic [CFG_W-1:0] final_gap;
    } cfg_t;

endpackage

// File: hw/rtl/bprr_front.sv
// Front end: accepts button words and classifies them as press, release or hold.
module bprr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_valid,
    output logic            tick_ready,
    input  logic            button_pressed,
    output logic            push_valid,
    input  logic            push_ready,
    output bprr_pkg::event_t push_event
);
    import bprr_pkg::*;

    logic last_pressed_reg;
    logic last_pressed_next;

    assign tick_ready = push_ready;
    assign push_valid = tick_valid;

    always_comb
    begin
        last_pressed_next = last_pressed_reg;
        if (tick_valid && push_ready)
        begin
            last_pressed_next = button_pressed;
        end
        if (!last_pressed_reg && button_pressed)
        begin
            push_event = EV_RISE;
        end
        else if (last_pressed_reg && !button_pressed)
        begin
            push_event = EV_FALL;
        end
        else
        begin
            push_event = EV_HOLD;
        end
    end

    // The level before the first word counts as pressed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pressed_reg <= 1'b1;
        end
        else
        begin
            last_pressed_reg <= last_pressed_next;
        end
    end

endmodule

// File: hw/rtl/bprr_queue.sv
// Short event queue between the front end and the back end.
module bprr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  bprr_pkg::event_t push_event,
    output logic             pop_valid,
    input  logic             pop_ready,
    output bprr_pkg::event_t pop_event
);
    import bprr_pkg::*;

    event_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_event  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_event;
        end
    end

endmodule

// File: hw/rtl/bprr_back.sv
// Back end: recording and playback sequencer with the duration memory and LED word register.
module bprr_back #(
    parameter int DEPTH       = bprr_pkg::DEPTH_DEF,
    parameter int COUNT_WIDTH = bprr_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bprr_pkg::cfg_t   cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  bprr_pkg::event_t q_event,
    output logic             led_valid,
    input  logic             led_ready,
    output logic             green_led,
    output logic             red_led
);
    import bprr_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WSW   = $clog2(DEPTH + 1);
    localparam int RSW   = $clog2(DEPTH + 3);
    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic [CW-1:0] mem [DEPTH];
    logic [CW-1:0] rdata_reg;
    logic          oob_reg;

    back_state_t   state_reg, state_next;
    logic          play_reg, play_next;
    logic [CW-1:0] run_reg, run_next;
    logic          started_reg, started_next;
    logic [WSW-1:0] wr_slot_reg, wr_slot_next;
    logic          held_reg, held_next;
    logic          rel_reg, rel_next;
    logic [RSW-1:0] rd_slot_reg, rd_slot_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [WSW-1:0] entries_reg, entries_next;
    logic          green_reg, green_next;
    logic          out_valid_reg;
    logic          out_green_reg;
    logic          out_red_reg;

    logic          can_emit;
    logic          emit;
    logic          rd_en;
    logic          wr_en;
    logic [CW-1:0] wr_data;
    logic          wr_ok;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] gap_sat;
    logic [CMP_W-1:0] gap_ext;
    logic [CW-1:0] dur;
    logic          load;

    assign can_emit  = !out_valid_reg || led_ready;
    assign led_valid = out_valid_reg;
    assign green_led = out_green_reg;
    assign red_led   = out_red_reg;

    assign wr_ok   = started_reg && (wr_slot_reg < WSW'(DEPTH));
    assign run_inc = (run_reg == CNT_MAX) ? CNT_MAX : run_reg + CW'(1);
    assign gap_ext = CMP_W'(cfg.final_gap);
    assign gap_sat = (gap_ext > CMP_W'(CNT_MAX)) ? CNT_MAX : gap_ext[CW-1:0];
    assign dur     = oob_reg ? '0 : rdata_reg;
    assign load    = (rd_slot_reg == '0) || (remain_reg <= CW'(1));

    always_comb
    begin
        state_next   = state_reg;
        play_next    = play_reg;
        run_next     = run_reg;
        started_next = started_reg;
        wr_slot_next = wr_slot_reg;
        held_next    = held_reg;
        rel_next     = rel_reg;
        rd_slot_next = rd_slot_reg;
        remain_next  = remain_reg;
        entries_next = entries_reg;
        green_next   = green_reg;
        q_ready      = 1'b0;
        emit         = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = run_inc;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && play_reg)
                begin
                    // Playback needs the stored duration first.
                    q_ready    = 1'b1;
                    rd_en      = 1'b1;
                    state_next = BK_PLAY;
                end
                else if (q_valid && can_emit)
                begin
                    q_ready = 1'b1;
                    emit    = 1'b1;
                    if (q_event == EV_RISE)
                    begin
                        held_next  = 1'b1;
                        rel_next   = 1'b0;
                        green_next = !green_reg;
                        if (started_reg)
                        begin
                            wr_en   = wr_ok;
                            wr_data = run_reg;
                            run_next = CW'(1);
                            if (wr_slot_reg < WSW'(DEPTH))
                            begin
                                wr_slot_next = wr_slot_reg + WSW'(1);
                            end
                        end
                        else
                        begin
                            run_next     = run_inc;
                            started_next = 1'b1;
                            wr_slot_next = '0;
                        end
                    end
                    else if (q_event == EV_FALL && (started_reg || run_reg != '0))
                    begin
                        held_next  = 1'b0;
                        rel_next   = 1'b1;
                        wr_en      = wr_ok;
                        wr_data    = run_inc;
                        green_next = !green_reg;
                        run_next   = '0;
                        if (!started_reg)
                        begin
                            started_next = 1'b1;
                            wr_slot_next = '0;
                        end
                        else if (wr_slot_reg < WSW'(DEPTH))
                        begin
                            wr_slot_next = wr_slot_reg + WSW'(1);
                        end
                    end
                    else if (held_reg || rel_reg)
                    begin
                        run_next = run_inc;
                        if ((CMP_W'(run_inc) >= CMP_W'(cfg.idle_timeout)) && !held_reg &&
                            started_reg)
                        begin
                            // Released long enough: close the recording with the gap entry.
                            entries_next = wr_slot_reg;
                            wr_en        = wr_ok;
                            wr_data      = gap_sat;
                            run_next     = '0;
                            play_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
            end
            BK_PLAY:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                    if (load)
                    begin
                        remain_next  = (dur == '0) ? CW'(1) : dur;
                        rd_slot_next = rd_slot_reg + RSW'(1);
                        green_next   = !green_reg;
                    end
                    else
                    begin
                        remain_next = remain_reg - CW'(1);
                    end
                    // One past the gap entry ends playback and rearms recording.
                    if (rd_slot_next == RSW'(entries_reg) + RSW'(2))
                    begin
                        play_next    = 1'b0;
                        run_next     = '0;
                        started_next = 1'b0;
                        wr_slot_next = '0;
                        held_next    = 1'b0;
                        rel_next     = 1'b0;
                        rd_slot_next = '0;
                        remain_next  = '0;
                        entries_next = '0;
                        green_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            play_reg      <= 1'b0;
            run_reg       <= '0;
            started_reg   <= 1'b0;
            wr_slot_reg   <= '0;
            held_reg      <= 1'b0;
            rel_reg       <= 1'b0;
            rd_slot_reg   <= '0;
            remain_reg    <= '0;
            entries_reg   <= '0;
            green_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            play_reg    <= play_next;
            run_reg     <= run_next;
            started_reg <= started_next;
            wr_slot_reg <= wr_slot_next;
            held_reg    <= held_next;
            rel_reg     <= rel_next;
            rd_slot_reg <= rd_slot_next;
            remain_reg  <= remain_next;
            entries_reg <= entries_next;
            green_reg   <= green_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (led_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_green_reg <= green_next;
            out_red_reg   <= !play_next;
        end
    end

    // Duration memory: one write port for recording, one registered read port for playback.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_slot_reg[AW-1:0]];
            oob_reg   <= !(rd_slot_reg < RSW'(DEPTH));
        end
    end

endmodule

// File: hw/rtl/button_pattern_record_replay.sv
// Top level of the button pattern recorder and replayer.
//
// Each button word is one tick and yields one LED word. While recording, the
// sustained rate is one word per cycle unless the LED output stalls; in playback
// a word first reads the duration memory (registered read) and then updates the
// countdown, and no new word is taken until its LED word is emitted. A two-entry
// queue sits between the edge classifier and the sequencer and holds new words
// while an LED word waits in the output register. The duration memory has DEPTH
// entries of COUNT_WIDTH bits and needs no clearing after reset. Configuration is
// to be written only while the block is idle; the block itself does not enforce it.
module button_pattern_record_replay #(
    parameter int DEPTH       = bprr_pkg::DEPTH_DEF,
    parameter int COUNT_WIDTH = bprr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_valid,
    output logic                           tick_ready,
    input  logic                           button_pressed,
    output logic                           led_valid,
    input  logic                           led_ready,
    output logic                           green_led,
    output logic                           red_led,
    input  logic                           cfg_we,
    input  logic [bprr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bprr_pkg::CFG_W-1:0]     cfg_data
);
    import bprr_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push_valid;
    logic   push_ready;
    event_t push_event;
    logic   pop_valid;
    logic   pop_ready;
    event_t pop_event;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = cfg_data;
                REG_FINAL_GAP:    cfg_next.final_gap    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout <= IDLE_TIMEOUT_RST;
            cfg_reg.final_gap    <= FINAL_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bprr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .button_pressed (button_pressed),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_event     (push_event)
    );

    bprr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_event (push_event),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_event  (pop_event)
    );

    bprr_back #(
        .DEPTH       (DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_event   (pop_event),
        .led_valid (led_valid),
        .led_ready (led_ready),
        .green_led (green_led),
        .red_led   (red_led)
    );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the button pattern recorder and replayer.
module tb_top;
    import bprr_pkg::*;

    localparam int          MEM_SLOTS     = DEPTH_DEF;
    localparam int unsigned COUNT_TOP     = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_LIMIT   = 4000;
    localparam int          PRINT_LIMIT   = 50;

    typedef struct packed {
        logic green;
        logic red;
    } led_word_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 tick_valid     = 1'b0;
    logic                 tick_ready;
    logic                 button_pressed = 1'b0;
    logic                 led_valid;
    logic                 led_ready      = 1'b0;
    logic                 green_led;
    logic                 red_led;
    logic                 cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = REG_IDLE_TIMEOUT;
    logic [CFG_W-1:0]     cfg_data       = '0;

    button_pattern_record_replay u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .button_pressed (button_pressed),
        .led_valid      (led_valid),
        .led_ready      (led_ready),
        .green_led      (green_led),
        .red_led        (red_led),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Button levels waiting to be sent and LED words still owed by the block.
    bit          tick_plan [$];
    led_word_t   led_expect [$];
    led_word_t   predicted;
    led_word_t   oldest;

    bit          pace      = 1'b1;
    logic        hold_led  = 1'b0;
    int unsigned send_gap  = 0;
    int unsigned recv_gap  = 0;
    int unsigned words_seen = 0;
    int unsigned fail_count = 0;

    // Shadow of the recorder state and its two registers.
    int unsigned idle_limit;
    int unsigned gap_value;
    bit          prev_pressed;
    bit          st_playing;
    int unsigned run_cnt;
    int          wr_slot;
    bit          st_held;
    bit          st_released;
    int unsigned dur_mem [MEM_SLOTS];
    int unsigned rd_slot;
    int unsigned remain;
    int unsigned taken;
    bit          green_now;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #48000000;
        $display("button_pattern_record_replay: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("error at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned bump(input int unsigned v);
        return (v >= COUNT_TOP) ? COUNT_TOP : v + 1;
    endfunction

    task automatic store_duration(input int slot, input int unsigned v);
        if (slot >= 0 && slot < MEM_SLOTS)
            dur_mem[slot] = (v > COUNT_TOP) ? COUNT_TOP : v;
    endtask

    task automatic wipe_recording();
        foreach (dur_mem[i])
            dur_mem[i] = 0;
        st_playing  = 1'b0;
        run_cnt     = 0;
        wr_slot     = -1;
        st_held     = 1'b0;
        st_released = 1'b0;
        rd_slot     = 0;
        remain      = 0;
        taken       = 0;
        green_now   = 1'b0;
    endtask

    // One tick: updates the shadow state and gives the LED word it causes.
    task automatic led_response(input bit pressed, output led_word_t w);
        int unsigned d;
        if (!st_playing) begin
            if (!prev_pressed && pressed) begin
                st_held     = 1'b1;
                st_released = 1'b0;
                green_now   = !green_now;
                if (wr_slot >= 0) begin
                    store_duration(wr_slot, run_cnt);
                    run_cnt = 0;
                    if (wr_slot < MEM_SLOTS)
                        wr_slot++;
                end
                run_cnt = bump(run_cnt);
                if (wr_slot < 0)
                    wr_slot = 0;
            end else if (prev_pressed && !pressed && (wr_slot >= 0 || run_cnt > 0)) begin
                st_held     = 1'b0;
                st_released = 1'b1;
                run_cnt     = bump(run_cnt);
                store_duration(wr_slot, run_cnt);
                green_now   = !green_now;
                run_cnt     = 0;
                if (wr_slot < MEM_SLOTS)
                    wr_slot++;
            end else if (st_held || st_released) begin
                run_cnt = bump(run_cnt);
                if (run_cnt >= idle_limit && !st_held && wr_slot >= 0) begin
                    taken = wr_slot;
                    store_duration(wr_slot, gap_value);
                    run_cnt    = 0;
                    st_playing = 1'b1;
                end
            end else begin
                run_cnt = 0;
            end
        end else begin
            if (rd_slot == 0 || remain <= 1) begin
                d         = (rd_slot < MEM_SLOTS) ? dur_mem[rd_slot] : 0;
                remain    = (d == 0) ? 1 : d;
                rd_slot++;
                green_now = !green_now;
            end else begin
                remain--;
            end
            if (rd_slot == taken + 2)
                wipe_recording();
        end
        prev_pressed = pressed;
        w.green = green_now;
        w.red   = !st_playing;
    endtask

    initial begin
        idle_limit   = IDLE_TIMEOUT_RST;
        gap_value    = FINAL_GAP_RST;
        prev_pressed = 1'b1;
        wipe_recording();
    end

    // Sender: draws a gap before each word and holds the word until taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tick_valid     <= 1'b0;
            button_pressed <= 1'b0;
        end else begin
            if (tick_valid && tick_ready) begin
                led_response(button_pressed, predicted);
                led_expect.push_back(predicted);
                send_gap = pace ? $urandom_range(0, 10) : 0;
            end
            if (tick_valid && !tick_ready) begin
                tick_valid <= 1'b1;
            end else if (send_gap != 0) begin
                send_gap--;
                tick_valid <= 1'b0;
            end else if (tick_plan.size() != 0) begin
                tick_valid     <= 1'b1;
                button_pressed <= tick_plan.pop_front();
            end else begin
                tick_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each LED word against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            led_ready <= 1'b0;
        end else begin
            if (led_valid && led_ready) begin
                if (led_expect.size() == 0) begin
                    flag_mismatch($sformatf("LED word %0d arrived with nothing expected",
                                            words_seen));
                end else begin
                    oldest = led_expect.pop_front();
                    if (green_led !== oldest.green)
                        flag_mismatch($sformatf("word %0d: green_led %b, expected %b",
                                                words_seen, green_led, oldest.green));
                    if (red_led !== oldest.red)
                        flag_mismatch($sformatf("word %0d: red_led %b, expected %b",
                                                words_seen, red_led, oldest.red));
                end
                words_seen++;
                recv_gap = pace ? $urandom_range(0, 10) : 0;
            end
            if (hold_led) begin
                led_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                led_ready <= 1'b0;
            end else begin
                led_ready <= 1'b1;
            end
        end
    end

    // A long receiver stall so that the internal queue fills and input backs up.
    initial begin
        wait (words_seen >= 300);
        @(posedge clk);
        hold_led <= 1'b1;
        repeat (300) @(posedge clk);
        hold_led <= 1'b0;
    end

    task automatic push_level(input bit lvl, input int unsigned n);
        repeat (n) tick_plan.push_back(lvl);
    endtask

    task automatic push_noise(input int unsigned n);
        repeat (n) tick_plan.push_back(1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        while (tick_plan.size() != 0 || tick_valid)
            @(negedge clk);
        while (led_expect.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (led_expect.size() != 0) begin
            flag_mismatch($sformatf("%0d LED words never arrived", led_expect.size()));
            led_expect.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IDLE_TIMEOUT)
            idle_limit = val;
        else
            gap_value = val;
        @(negedge clk);
    endtask

    task automatic finish_playback();
        settle();
        while (st_playing) begin
            push_noise(256);
            settle();
        end
    endtask

    // A recorded pattern of press and release runs, normally closed by an idle
    // release that starts playback, followed by enough ticks to play it out.
    task automatic record_take(input bit fill, output int unsigned pushed);
        int unsigned pairs;
        int unsigned p;
        int unsigned r;
        int unsigned total;
        pairs = fill ? $urandom_range(33, 40) : $urandom_range(1, 6);
        total = 1;
        push_level(1'b0, 1);
        repeat (pairs) begin
            p = $urandom_range(1, 6);
            r = $urandom_range(1, (idle_limit < 5) ? idle_limit : 5);
            push_level(1'b1, p);
            push_level(1'b0, r);
            total += p + r;
        end
        if ($urandom_range(0, 7) != 0) begin
            push_level(1'b0, idle_limit + $urandom_range(0, 2));
            total += idle_limit + 2;
            push_noise(total + gap_value + 4);
            total += total + gap_value + 4;
        end
        pushed = total;
    endtask

    initial begin
        bit          opening [10]   = '{0, 0, 1, 1, 1, 0, 1, 0, 0, 0};
        bit          zero_regs [10] = '{0, 1, 0, 1, 1, 0, 0, 1, 0, 1};
        int unsigned phase_items;
        int unsigned pushed;

        @(posedge rst_n);
        @(negedge clk);

        // Reset register values: a release before any press, a first press,
        // a one-tick release that stores a zero duration.
        foreach (opening[i])
            tick_plan.push_back(opening[i]);
        settle();

        // Both registers at zero: playback starts on the next released tick
        // and the final gap plays as one tick; the button is ignored meanwhile.
        write_register(REG_IDLE_TIMEOUT, '0);
        write_register(REG_FINAL_GAP, '0);
        foreach (zero_regs[i])
            tick_plan.push_back(zero_regs[i]);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            pace = (ph != 3);
            if (ph == 0) begin
                write_register(REG_IDLE_TIMEOUT, 16'd1);
                write_register(REG_FINAL_GAP, 16'd1);
            end else begin
                write_register(REG_IDLE_TIMEOUT, CFG_W'($urandom_range(1, 24)));
                write_register(REG_FINAL_GAP, CFG_W'($urandom_range(1, 40)));
            end
            phase_items = 0;
            while (phase_items < 120) begin
                if ($urandom_range(0, 4) == 0) begin
                    pushed = $urandom_range(1, 12);
                    push_noise(pushed);
                end else begin
                    record_take(ph == 1 && phase_items == 0, pushed);
                end
                phase_items += pushed;
            end
            settle();
        end

        finish_playback();

        if (fail_count == 0)
            $display("button_pattern_record_replay: match");
        else
            $display("button_pattern_record_replay: mismatch");
        $finish;
    end

endmodule
